>>> rtl/i2c_master_byte_engine_assert.svh
// Assertion macros for the I2C master byte engine checker.
// Depends on nothing; include by bare file name.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define I2C_MBE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define I2C_MBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/i2c_mbe_pkg.sv
// Shared constants and types for the I2C master byte engine.
// No dependencies; used by the front, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package i2c_mbe_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DELAY_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request op codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_RSTART    = 3'd2;
  localparam logic [2:0] OP_STOP      = 3'd3;
  localparam logic [2:0] OP_WRITE     = 3'd4;
  localparam logic [2:0] OP_READ_ACK  = 3'd5;
  localparam logic [2:0] OP_READ_NACK = 3'd6;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_RSTART,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ_ACK,
    KIND_READ_NACK,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] wdata;
    logic       sda;
  } q_item_t;

endpackage

`default_nettype wire

>>> rtl/i2c_mbe_if.sv
// Valid/ready channel interfaces for the I2C master byte engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] wdata;
  logic       sda_in;

  modport source (output valid, op, wdata, sda_in, input ready);
  modport sink (input valid, op, wdata, sda_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       ack_received;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_data, ack_received,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_data, ack_received,
                output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_mbe_front.sv
// Front end: accepts requests, classifies the op code and queues them.
// Depends on i2c_mbe_pkg and i2c_mbe_in_if.
`timescale 1ns / 1ps
`default_nettype none

module i2c_mbe_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  i2c_mbe_in_if.sink               in_chan,
  output      logic                q_valid,
  output      i2c_mbe_pkg::q_item_t q_item,
  input  wire logic                q_pop
);

  i2c_mbe_pkg::q_item_t                    mem_r [i2c_mbe_pkg::QUEUE_DEPTH];
  logic [i2c_mbe_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [i2c_mbe_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [i2c_mbe_pkg::QCNT_W-1:0]          count_r, count_nxt;
  i2c_mbe_pkg::q_item_t                    new_item;
  logic                                    push;

  always_comb begin
    new_item.wdata = in_chan.wdata;
    new_item.sda   = in_chan.sda_in;
    unique case (in_chan.op)
      i2c_mbe_pkg::OP_TICK:      new_item.kind = i2c_mbe_pkg::KIND_TICK;
      i2c_mbe_pkg::OP_START:     new_item.kind = i2c_mbe_pkg::KIND_START;
      i2c_mbe_pkg::OP_RSTART:    new_item.kind = i2c_mbe_pkg::KIND_RSTART;
      i2c_mbe_pkg::OP_STOP:      new_item.kind = i2c_mbe_pkg::KIND_STOP;
      i2c_mbe_pkg::OP_WRITE:     new_item.kind = i2c_mbe_pkg::KIND_WRITE;
      i2c_mbe_pkg::OP_READ_ACK:  new_item.kind = i2c_mbe_pkg::KIND_READ_ACK;
      i2c_mbe_pkg::OP_READ_NACK: new_item.kind = i2c_mbe_pkg::KIND_READ_NACK;
      default:                   new_item.kind = i2c_mbe_pkg::KIND_NONE;
    endcase
  end

  assign in_chan.ready = (count_r != i2c_mbe_pkg::QCNT_W'(i2c_mbe_pkg::QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != '0);
  assign q_item        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == i2c_mbe_pkg::QPTR_W'(i2c_mbe_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == i2c_mbe_pkg::QPTR_W'(i2c_mbe_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2c_mbe_back.sv
// Back end: bus phase sequencer, wait counter, shifter and result register.
// Depends on i2c_mbe_pkg and i2c_mbe_out_if.
`timescale 1ns / 1ps
`default_nettype none

module i2c_mbe_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [i2c_mbe_pkg::DELAY_W-1:0] cfg_wdata,
  input  wire logic                      q_valid,
  input  wire i2c_mbe_pkg::q_item_t      q_item,
  output      logic                      q_pop,
  i2c_mbe_out_if.source                  out_chan
);

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A, PH_ST_B,
    PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D,
    PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
    PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH,
    PH_WA_LOW, PH_WA_HIGH,
    PH_RD_LOW, PH_RD_HIGH, PH_RD_HOLD,
    PH_AK_LOW, PH_AK_DATA, PH_AK_HIGH
  } phase_t;

  localparam int CW = i2c_mbe_pkg::COUNT_WIDTH;

  phase_t                            phase_r, phase_nxt;
  logic [CW-1:0]                     wait_r, wait_nxt;
  logic [2:0]                        bit_r, bit_nxt;
  logic [7:0]                        shift_r, shift_nxt;
  logic                              scl_r, scl_nxt;
  logic                              sda_r, sda_nxt;
  logic                              ack_r, ack_nxt;
  logic                              ack_rd_r, ack_rd_nxt;
  logic [7:0]                        rx_r, rx_nxt;
  logic                              done_r, done_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [i2c_mbe_pkg::DELAY_W-1:0]   delay_r;
  logic [CW-1:0]                     full_w, half_w, load_full, load_half;
  logic                              enter;
  logic                              step;

  assign full_w    = CW'(delay_r);
  assign half_w    = full_w >> 1;
  assign load_full = (full_w == '0) ? CW'(1) : full_w;
  assign load_half = (half_w == '0) ? CW'(1) : half_w;

  // Advance one request whenever the result slot is free or being drained.
  assign step  = q_valid && (!out_valid_r || out_chan.ready);
  assign q_pop = step;

  always_comb begin
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    ack_rd_nxt = ack_rd_r;
    rx_nxt     = rx_r;
    done_nxt   = 1'b0;
    enter      = 1'b0;

    if (phase_r == PH_IDLE) begin
      enter   = 1'b1;
      bit_nxt = '0;
      unique case (q_item.kind)
        i2c_mbe_pkg::KIND_START:  phase_nxt = PH_ST_A;
        i2c_mbe_pkg::KIND_RSTART: phase_nxt = PH_RS_A;
        i2c_mbe_pkg::KIND_STOP:   phase_nxt = PH_SP_A;
        i2c_mbe_pkg::KIND_WRITE: begin
          shift_nxt = q_item.wdata;
          phase_nxt = PH_WR_LOW;
        end
        i2c_mbe_pkg::KIND_READ_ACK, i2c_mbe_pkg::KIND_READ_NACK: begin
          shift_nxt  = '0;
          ack_rd_nxt = (q_item.kind == i2c_mbe_pkg::KIND_READ_ACK);
          phase_nxt  = PH_RD_LOW;
        end
        default: begin
          // Tick or reserved code while idle: hold everything.
          enter   = 1'b0;
          bit_nxt = bit_r;
        end
      endcase
    end else if (q_item.kind == i2c_mbe_pkg::KIND_TICK) begin
      if (wait_r > CW'(1)) begin
        wait_nxt = wait_r - 1'b1;
      end else begin
        wait_nxt = '0;
        unique case (phase_r)
          PH_ST_A:    phase_nxt = PH_ST_B;
          PH_RS_A:    phase_nxt = PH_RS_B;
          PH_RS_B:    phase_nxt = PH_RS_C;
          PH_RS_C:    phase_nxt = PH_RS_D;
          PH_SP_A:    phase_nxt = PH_SP_B;
          PH_SP_B:    phase_nxt = PH_SP_C;
          PH_SP_C:    phase_nxt = PH_SP_D;
          PH_WR_LOW:  phase_nxt = PH_WR_DATA;
          PH_WR_DATA: phase_nxt = PH_WR_HIGH;
          PH_WR_HIGH: begin
            if (bit_r == i2c_mbe_pkg::BIT_LAST) begin
              phase_nxt = PH_WA_LOW;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_WR_LOW;
            end
          end
          PH_WA_LOW:  phase_nxt = PH_WA_HIGH;
          PH_WA_HIGH: begin
            ack_nxt   = q_item.sda;
            phase_nxt = PH_IDLE;
          end
          PH_RD_LOW:  phase_nxt = PH_RD_HIGH;
          PH_RD_HIGH: begin
            shift_nxt = {shift_r[6:0], q_item.sda};
            phase_nxt = PH_RD_HOLD;
          end
          PH_RD_HOLD: begin
            if (bit_r == i2c_mbe_pkg::BIT_LAST) begin
              rx_nxt    = shift_r;
              phase_nxt = PH_AK_LOW;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_RD_LOW;
            end
          end
          PH_AK_LOW:  phase_nxt = PH_AK_DATA;
          PH_AK_DATA: phase_nxt = PH_AK_HIGH;
          default:    phase_nxt = PH_IDLE;
        endcase
        if (phase_nxt == PH_IDLE) begin
          done_nxt = 1'b1;
        end else begin
          enter = 1'b1;
        end
      end
    end

    // Apply the line levels and wait of the phase being entered.
    if (enter) begin
      unique case (phase_nxt)
        PH_ST_A:    begin sda_nxt = 1'b1; scl_nxt = 1'b1; wait_nxt = load_full; end
        PH_ST_B:    begin sda_nxt = 1'b0; wait_nxt = load_full; end
        PH_RS_A:    begin scl_nxt = 1'b0; wait_nxt = load_half; end
        PH_RS_B:    begin sda_nxt = 1'b1; wait_nxt = load_half; end
        PH_RS_C:    begin scl_nxt = 1'b1; wait_nxt = load_half; end
        PH_RS_D:    begin sda_nxt = 1'b0; wait_nxt = load_full; end
        PH_SP_A:    begin scl_nxt = 1'b0; wait_nxt = load_half; end
        PH_SP_B:    begin sda_nxt = 1'b0; wait_nxt = load_half; end
        PH_SP_C:    begin scl_nxt = 1'b1; wait_nxt = load_half; end
        PH_SP_D:    begin sda_nxt = 1'b1; wait_nxt = load_full; end
        PH_WR_LOW:  begin scl_nxt = 1'b0; wait_nxt = load_full; end
        PH_WR_DATA: begin
          sda_nxt  = shift_nxt[3'(i2c_mbe_pkg::BIT_LAST - bit_nxt)];
          wait_nxt = load_half;
        end
        PH_WR_HIGH: begin scl_nxt = 1'b1; wait_nxt = load_full; end
        PH_WA_LOW:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = load_half; end
        PH_WA_HIGH: begin scl_nxt = 1'b1; wait_nxt = load_full; end
        PH_RD_LOW:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = load_full; end
        PH_RD_HIGH: begin scl_nxt = 1'b1; wait_nxt = load_half; end
        PH_RD_HOLD: wait_nxt = load_full;
        PH_AK_LOW:  begin scl_nxt = 1'b0; wait_nxt = load_half; end
        PH_AK_DATA: begin sda_nxt = !ack_rd_nxt; wait_nxt = load_half; end
        PH_AK_HIGH: begin scl_nxt = 1'b1; wait_nxt = load_full; end
        default:    wait_nxt = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      ack_rd_r    <= 1'b0;
      rx_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r  <= phase_nxt;
        wait_r   <= wait_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        ack_r    <= ack_nxt;
        ack_rd_r <= ack_rd_nxt;
        rx_r     <= rx_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= i2c_mbe_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.scl_out      = scl_r;
  assign out_chan.sda_out      = sda_r;
  assign out_chan.busy_res     = (phase_r != PH_IDLE);
  assign out_chan.done_res     = done_r;
  assign out_chan.rx_data      = rx_r;
  assign out_chan.ack_received = ack_r;

endmodule

`default_nettype wire

>>> rtl/i2c_master_byte_engine.sv
// I2C master byte engine, top level: front queue plus bus sequencer.
// Depends on i2c_mbe_pkg, i2c_mbe_if, i2c_mbe_front and i2c_mbe_back.
//
// Each request on in_chan is either a tick (op 0, carrying the sampled SDA
// level) or, while the engine is idle, a bus command: start, repeated start,
// stop, write byte, or read byte followed by ACK or NACK. Every request gives
// exactly one result on out_chan with the SCL level, SDA drive, busy, done,
// the last read byte and the last write acknowledge. Commands sent while busy
// and op code 7 are ignored but still answered. Phase waits last
// delay_ticks ticks (full) or delay_ticks>>1 ticks (half), at least one tick.
// Throughput is one request per clock while out_chan is not stalled: the
// sequencer retires one request per cycle, and a two-entry queue in front
// of it takes requests while a result waits, dropping in_chan.ready when
// full. A request is registered in the queue, then its result on out_chan.
// delay_ticks is written through cfg_we/cfg_wdata and must only change
// while no request is in flight. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  i2c_mbe_in_if.sink                             in_chan,
  i2c_mbe_out_if.source                          out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [i2c_mbe_pkg::DELAY_W-1:0]   cfg_wdata
);

  // Queue handoff between the front and the sequencer
  logic                 q_valid;
  logic                 q_pop;
  i2c_mbe_pkg::q_item_t q_item;

  // Accept and classify requests; hold up to two ahead of the sequencer.
  i2c_mbe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Run the bus phases, count waits and drive the result register.
  i2c_mbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

>>> rtl/i2c_mbe_checker.sv
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2c_master_byte_engine_assert.svh and i2c_master_byte_engine.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_assert.svh"

module i2c_mbe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       scl_out,
  input wire logic       sda_out,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] rx_data,
  input wire logic       ack_received
);

  logic [12:0] result_bits;

  assign result_bits = {scl_out, sda_out, busy_res, done_res, rx_data, ack_received};

  // A stalled result holds its payload.
  `I2C_MBE_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(result_bits)), "result changed while stalled")

  // A finishing sequence leaves the engine idle.
  `I2C_MBE_ASSERT(a_done_idle, clk, rst_n, (out_valid && done_res) |-> !busy_res, "done while busy")

  // Every command sequence ends with SCL released.
  `I2C_MBE_ASSERT(a_idle_scl, clk, rst_n, (out_valid && !busy_res) |-> scl_out, "SCL low while idle")

  // Reset empties the queue and the result slot.
  `I2C_MBE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (in_ready && !out_valid), "not empty after reset")

endmodule

bind i2c_master_byte_engine i2c_mbe_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .scl_out      (out_chan.scl_out),
  .sda_out      (out_chan.sda_out),
  .busy_res     (out_chan.busy_res),
  .done_res     (out_chan.done_res),
  .rx_data      (out_chan.rx_data),
  .ack_received (out_chan.ack_received)
);

`default_nettype wire

>>> bench/tb_i2c_master_byte_engine.sv
// Self-checking bench for the I2C master byte engine: drives requests, predicts every result field.
// Depends on i2c_mbe_pkg, the i2c_mbe_in_if/i2c_mbe_out_if interfaces and the engine itself.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;

  // Op code 7 has no meaning; the engine must answer it and change nothing.
  localparam logic [2:0] OP_RESERVED = 3'd7;
  // Tick SDA pattern selector: fixed 0, fixed 1, or random per tick.
  localparam int SDA_RANDOM = 2;
  localparam int NO_CUT = -1;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 4000;

  // Bus sequencer steps, in the order each command walks through them.
  typedef enum logic [4:0] {
    BUS_IDLE,
    ST_SETUP, ST_FALL,
    RS_SCL_LOW, RS_SDA_HIGH, RS_SCL_HIGH, RS_SDA_LOW,
    SP_SCL_LOW, SP_SDA_LOW, SP_SCL_HIGH, SP_SDA_HIGH,
    WR_SCL_LOW, WR_SDA_SET, WR_SCL_HIGH,
    WA_SCL_LOW, WA_SCL_HIGH,
    RD_SCL_LOW, RD_SCL_HIGH, RD_HOLD,
    AK_SCL_LOW, AK_SDA_SET, AK_SCL_HIGH
  } bus_step_t;

  typedef struct {
    logic [2:0] op;
    logic [7:0] wdata;
    logic       sda;
  } bus_req_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } bus_lines_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [i2c_mbe_pkg::DELAY_W-1:0] cfg_wdata;

  i2c_mbe_in_if  in_if();
  i2c_mbe_out_if out_if();

  i2c_master_byte_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Request stream waiting to be driven, and the bus lines expected back.
  bus_req_t   pending_requests[$];
  bus_lines_t expected_lines[$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  // Shadow of the engine: delay register plus sequencer state, reset values.
  logic [i2c_mbe_pkg::DELAY_W-1:0] bus_delay = i2c_mbe_pkg::DELAY_RESET;
  bus_step_t          bus_step       = BUS_IDLE;
  logic [15:0]        bus_wait       = '0;
  logic [2:0]         bit_pos        = '0;
  logic [7:0]         shift_reg      = '0;
  logic               scl_lvl        = 1'b1;
  logic               sda_lvl        = 1'b1;
  logic               ack_lvl        = 1'b0;
  logic               ack_after_read = 1'b0;
  logic [7:0]         rx_byte        = '0;

  // Load the step wait; a zero-length wait still costs one tick.
  function automatic void load_wait(bit half);
    logic [15:0] w;
    w = half ? (bus_delay >> 1) : bus_delay;
    bus_wait = (w == 16'd0) ? 16'd1 : w;
  endfunction

  // Drive the line levels of the current step and start its wait.
  function automatic void apply_step();
    case (bus_step)
      ST_SETUP: begin
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
        load_wait(1'b0);
      end
      ST_FALL: begin
        sda_lvl = 1'b0;
        load_wait(1'b0);
      end
      RS_SCL_LOW: begin
        scl_lvl = 1'b0;
        load_wait(1'b1);
      end
      RS_SDA_HIGH: begin
        sda_lvl = 1'b1;
        load_wait(1'b1);
      end
      RS_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b1);
      end
      RS_SDA_LOW: begin
        sda_lvl = 1'b0;
        load_wait(1'b0);
      end
      SP_SCL_LOW: begin
        scl_lvl = 1'b0;
        load_wait(1'b1);
      end
      SP_SDA_LOW: begin
        sda_lvl = 1'b0;
        load_wait(1'b1);
      end
      SP_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b1);
      end
      SP_SDA_HIGH: begin
        sda_lvl = 1'b1;
        load_wait(1'b0);
      end
      WR_SCL_LOW: begin
        scl_lvl = 1'b0;
        load_wait(1'b0);
      end
      WR_SDA_SET: begin
        sda_lvl = shift_reg[3'd7 - bit_pos];
        load_wait(1'b1);
      end
      WR_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b0);
      end
      WA_SCL_LOW: begin
        // Release SDA so the slave can pull it for its acknowledge.
        scl_lvl = 1'b0;
        sda_lvl = 1'b1;
        load_wait(1'b1);
      end
      WA_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b0);
      end
      RD_SCL_LOW: begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b1;
        load_wait(1'b0);
      end
      RD_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b1);
      end
      RD_HOLD: load_wait(1'b0);
      AK_SCL_LOW: begin
        scl_lvl = 1'b0;
        load_wait(1'b1);
      end
      AK_SDA_SET: begin
        sda_lvl = !ack_after_read;
        load_wait(1'b1);
      end
      AK_SCL_HIGH: begin
        scl_lvl = 1'b1;
        load_wait(1'b0);
      end
      default: begin
        bus_step = BUS_IDLE;
        bus_wait = '0;
      end
    endcase
  endfunction

  // Close the current step (sampling SDA where the step samples) and pick the next.
  function automatic bus_step_t next_step(logic sda);
    case (bus_step)
      ST_SETUP:    return ST_FALL;
      RS_SCL_LOW:  return RS_SDA_HIGH;
      RS_SDA_HIGH: return RS_SCL_HIGH;
      RS_SCL_HIGH: return RS_SDA_LOW;
      SP_SCL_LOW:  return SP_SDA_LOW;
      SP_SDA_LOW:  return SP_SCL_HIGH;
      SP_SCL_HIGH: return SP_SDA_HIGH;
      WR_SCL_LOW:  return WR_SDA_SET;
      WR_SDA_SET:  return WR_SCL_HIGH;
      WR_SCL_HIGH: begin
        if (bit_pos == i2c_mbe_pkg::BIT_LAST) return WA_SCL_LOW;
        bit_pos = bit_pos + 3'd1;
        return WR_SCL_LOW;
      end
      WA_SCL_LOW:  return WA_SCL_HIGH;
      WA_SCL_HIGH: begin
        ack_lvl = sda;
        return BUS_IDLE;
      end
      RD_SCL_LOW:  return RD_SCL_HIGH;
      RD_SCL_HIGH: begin
        shift_reg = {shift_reg[6:0], sda};
        return RD_HOLD;
      end
      RD_HOLD: begin
        if (bit_pos == i2c_mbe_pkg::BIT_LAST) begin
          rx_byte = shift_reg;
          return AK_SCL_LOW;
        end
        bit_pos = bit_pos + 3'd1;
        return RD_SCL_LOW;
      end
      AK_SCL_LOW:  return AK_SDA_SET;
      AK_SDA_SET:  return AK_SCL_HIGH;
      default:     return BUS_IDLE;
    endcase
  endfunction

  // Advance the shadow engine by one request and return the lines it should show.
  function automatic bus_lines_t advance_bus(logic [2:0] op, logic [7:0] wdata, logic sda);
    bus_lines_t lines;
    lines.done = 1'b0;
    if (bus_step == BUS_IDLE) begin
      if (op != i2c_mbe_pkg::OP_TICK && op != OP_RESERVED) begin
        bit_pos = '0;
        case (op)
          i2c_mbe_pkg::OP_START:  bus_step = ST_SETUP;
          i2c_mbe_pkg::OP_RSTART: bus_step = RS_SCL_LOW;
          i2c_mbe_pkg::OP_STOP:   bus_step = SP_SCL_LOW;
          i2c_mbe_pkg::OP_WRITE: begin
            shift_reg = wdata;
            bus_step  = WR_SCL_LOW;
          end
          default: begin
            shift_reg      = '0;
            ack_after_read = (op == i2c_mbe_pkg::OP_READ_ACK);
            bus_step       = RD_SCL_LOW;
          end
        endcase
        apply_step();
      end
    end else if (op == i2c_mbe_pkg::OP_TICK) begin
      if (bus_wait > 16'd1) begin
        bus_wait = bus_wait - 16'd1;
      end else begin
        bus_wait = '0;
        bus_step = next_step(sda);
        if (bus_step == BUS_IDLE) lines.done = 1'b1;
        else apply_step();
      end
    end
    lines.scl  = scl_lvl;
    lines.sda  = sda_lvl;
    lines.busy = (bus_step != BUS_IDLE);
    lines.rx   = rx_byte;
    lines.ack  = ack_lvl;
    return lines;
  endfunction

  // Ticks a command needs from its request until its done tick, at the current delay.
  function automatic int command_ticks(logic [2:0] op);
    int full_w;
    int half_w;
    full_w = (bus_delay == 0) ? 1 : int'(bus_delay);
    half_w = ((bus_delay >> 1) == 0) ? 1 : int'(bus_delay >> 1);
    case (op)
      i2c_mbe_pkg::OP_START:
        return 2 * full_w;
      i2c_mbe_pkg::OP_RSTART, i2c_mbe_pkg::OP_STOP:
        return 3 * half_w + full_w;
      i2c_mbe_pkg::OP_WRITE:
        return 8 * (2 * full_w + half_w) + half_w + full_w;
      i2c_mbe_pkg::OP_READ_ACK, i2c_mbe_pkg::OP_READ_NACK:
        return 8 * (2 * full_w + half_w) + 2 * half_w + full_w;
      default:
        return 0;
    endcase
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_request(logic [2:0] op, logic [7:0] wdata, logic sda);
    bus_req_t req;
    req.op    = op;
    req.wdata = wdata;
    req.sda   = sda;
    pending_requests.push_back(req);
  endtask

  task automatic queue_ticks(int count, int sda_pattern);
    for (int k = 0; k < count; k++)
      push_request(i2c_mbe_pkg::OP_TICK, 8'($urandom),
                   (sda_pattern == SDA_RANDOM) ? 1'($urandom) : 1'(sda_pattern));
  endtask

  // Queue a command plus the ticks that carry it to done. With a cut point,
  // slip a stray command or reserved op into the busy window at that tick.
  task automatic queue_command(logic [2:0] op, logic [7:0] data, int extra,
                               int sda_pattern, int cut);
    int total;
    total = command_ticks(op) + extra;
    push_request(op, data, 1'($urandom));
    if (cut >= 0 && cut < total) begin
      queue_ticks(cut, sda_pattern);
      push_request(3'($urandom_range(i2c_mbe_pkg::OP_START, OP_RESERVED)), 8'($urandom),
                   1'($urandom));
      queue_ticks(total - cut, sda_pattern);
    end else begin
      queue_ticks(total, sda_pattern);
    end
  endtask

  // Mostly complete commands with random content; the rest is interrupted
  // sequences and stray requests while the bus sits idle.
  task automatic queue_random_traffic(int n_items);
    int goal;
    int pick;
    logic [2:0] op;
    goal = pending_requests.size() + n_items;
    while (pending_requests.size() < goal) begin
      pick = $urandom_range(0, 99);
      op   = 3'($urandom_range(i2c_mbe_pkg::OP_START, i2c_mbe_pkg::OP_READ_NACK));
      if (pick < 70)
        queue_command(op, 8'($urandom), $urandom_range(0, 2), SDA_RANDOM, NO_CUT);
      else if (pick < 88)
        queue_command(op, 8'($urandom), 0, SDA_RANDOM,
                      $urandom_range(0, command_ticks(op) - 1));
      else
        push_request($urandom_range(0, 1) ? OP_RESERVED : i2c_mbe_pkg::OP_TICK,
                     8'($urandom), 1'($urandom));
    end
  endtask

  // Hold until every request is driven and answered, then let the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_if.valid || expected_lines.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the delay register with the engine drained, then pick the idling mix.
  task automatic start_phase(logic [i2c_mbe_pkg::DELAY_W-1:0] value, int send_pct,
                             int stall_pct);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bus_delay = value;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Driver: offer the next request whenever the channel is free, idling at random.
  always @(posedge clk) begin : request_driver
    bus_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_if.valid  <= 1'b1;
        in_if.op     <= nxt.op;
        in_if.wdata  <= nxt.wdata;
        in_if.sda_in <= nxt.sda;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request; each request yields exactly one result.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      expected_lines.push_back(advance_bus(in_if.op, in_if.wdata, in_if.sda_in));
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    bus_lines_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_lines.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          check_field("scl_out", 8'(want.scl), 8'(out_if.scl_out));
          check_field("sda_out", 8'(want.sda), 8'(out_if.sda_out));
          check_field("busy_res", 8'(want.busy), 8'(out_if.busy_res));
          check_field("done_res", 8'(want.done), 8'(out_if.done_res));
          check_field("rx_data", want.rx, out_if.rx_data);
          check_field("ack_received", 8'(want.ack), 8'(out_if.ack_received));
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : test_sequence
    logic [i2c_mbe_pkg::DELAY_W-1:0] rand_delays[7];
    rand_delays = '{16'd2, 16'd3, 16'd1, 16'd0, 16'd5, 16'd2, 16'd4};

    // Hold every input at a known level through reset.
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = i2c_mbe_pkg::DELAY_RESET;
    in_if.valid  = 1'b0;
    in_if.op     = i2c_mbe_pkg::OP_TICK;
    in_if.wdata  = '0;
    in_if.sda_in = 1'b1;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset delay, untouched register: idle ticks and a reserved op change
    // nothing; a start then runs while a write and a reserved op are ignored.
    push_request(i2c_mbe_pkg::OP_TICK, 8'h00, 1'b0);
    push_request(i2c_mbe_pkg::OP_TICK, 8'hFF, 1'b1);
    push_request(OP_RESERVED, 8'hFF, 1'b1);
    push_request(i2c_mbe_pkg::OP_START, 8'h00, 1'b0);
    push_request(i2c_mbe_pkg::OP_WRITE, 8'hA5, 1'b1);
    push_request(OP_RESERVED, 8'h00, 1'b0);
    queue_ticks(command_ticks(i2c_mbe_pkg::OP_START) + 1, SDA_RANDOM);

    // Delay 2, the smallest with a nonzero half wait: every command once, with both ACK levels and
    // all-ones / all-zeros bytes on the wire.
    start_phase(16'd2, 0, 0);
    queue_command(i2c_mbe_pkg::OP_RSTART, 8'h00, 0, SDA_RANDOM, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_STOP, 8'h00, 0, SDA_RANDOM, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_WRITE, 8'hFF, 0, 0, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_WRITE, 8'h00, 0, 1, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_READ_ACK, 8'h00, 0, 1, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_READ_NACK, 8'hFF, 0, 0, NO_CUT);
    queue_command(i2c_mbe_pkg::OP_START, 8'h00, 1, SDA_RANDOM, NO_CUT);

    // Random traffic across delays, including the zero-length half waits
    // at delays 0 and 1, rotating through the idling mixes.
    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: start_phase(rand_delays[p], 0, 0);
        1: start_phase(rand_delays[p], 62, 0);
        2: start_phase(rand_delays[p], 0, 62);
        default: start_phase(rand_delays[p], 22, 22);
      endcase
      queue_random_traffic(90);
    end

    // Largest delay: open a start and count down the first part of its
    // full wait, driven back to back.
    start_phase(16'hFFFF, 0, 0);
    push_request(i2c_mbe_pkg::OP_START, 8'h00, 1'b1);
    queue_ticks(20, SDA_RANDOM);

    drain();
    if (mismatches == 0 && expected_lines.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
